/* design/dpmppt_pkg.sv */
// ----------------------------------------------------------------------------
// Dual-panel MPPT package
// Shared widths, reset values and lane types for the perturb-and-observe core.
// ----------------------------------------------------------------------------
package dpmppt_pkg;

  // Fixed field widths.
  localparam int unsigned FieldWidth = 16;
  localparam int unsigned PowerWidth = 32;
  localparam int unsigned DutyWidth  = 8;

  // Default number of sample bits that enter the power product.
  localparam int unsigned SampleWidthDefault = 16;

  // Reset values.
  localparam logic [DutyWidth-1:0]  DutyStepReset = 8'h06;
  localparam logic [DutyWidth-1:0]  DutyReset     = 8'h3F;
  localparam logic [PowerWidth-1:0] PowerReset    = 32'hFFFF_FFFF;

  // Pipeline control handed to each lane.
  typedef struct packed {
    logic load;     // a sample word enters the product register
    logic advance;  // the product register moves on and the state updates
  } lane_ctrl_t;

  // What one lane found for the current word.
  typedef struct packed {
    logic [DutyWidth-1:0] duty;
    logic                 dir;
  } lane_result_t;

endpackage

/* design/dual_panel_mppt_perturb_observe_core.sv */
// ----------------------------------------------------------------------------
// Dual-panel perturb-and-observe MPPT core
// Tracks the maximum power point of two solar panels, X and Y, in two lanes.
// ----------------------------------------------------------------------------
// Usage:
// - The input channel (in_valid_i / in_ready_o) takes one word holding the
//   voltage and current samples of both panels.
// - The output channel (out_valid_o / out_ready_i) returns one word per input
//   word: the new duty cycle and direction of each panel.
// - The configuration channel (cfg_valid_i / cfg_ready_o) writes the duty
//   step; it is always ready. The user must see that it is written only while
//   the core is idle; the core itself does not enforce this.
// - An accepted word loads the product register of each lane's multiplier
//   (SampleWidth x SampleWidth, 16x16 by default); the compare-and-step logic
//   then loads the output register. Throughput is one word per cycle while
//   the receiver does not stall; the stored power of each lane is updated by
//   the step logic in order, so consecutive words flow freely.
// - Reset clears the pipeline, sets both stored powers to all ones, both
//   directions to 0, both duties to 63 and the duty step to 6.
// - When the receiver stalls, the output word holds, the product stage
//   fills, and then in_ready_o drops until the output is taken.
// ----------------------------------------------------------------------------
module dual_panel_mppt_perturb_observe_core #(
  parameter int unsigned SampleWidth = dpmppt_pkg::SampleWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dpmppt_pkg::DutyWidth-1:0]   cfg_data_i,
  // Input channel.
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [dpmppt_pkg::FieldWidth-1:0]  x_panel_volts_i,
  input  logic [dpmppt_pkg::FieldWidth-1:0]  x_panel_amps_i,
  input  logic [dpmppt_pkg::FieldWidth-1:0]  y_panel_volts_i,
  input  logic [dpmppt_pkg::FieldWidth-1:0]  y_panel_amps_i,
  // Output channel.
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dpmppt_pkg::DutyWidth-1:0]   x_duty_out_o,
  output logic [dpmppt_pkg::DutyWidth-1:0]   y_duty_out_o,
  output logic                               x_dir_out_o,
  output logic                               y_dir_out_o
);
  import dpmppt_pkg::*;

  logic [DutyWidth-1:0] duty_step_val_q;
  logic                 prod_valid_q;
  logic                 can_load;
  lane_ctrl_t           ctrl;
  lane_result_t         x_result, y_result;

  // Duty step register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_step_val_q <= DutyStepReset;
    end else if (cfg_valid_i) begin
      duty_step_val_q <= cfg_data_i;
    end
  end

  // Product stage occupancy and pipeline control.
  assign ctrl.advance = prod_valid_q && can_load;
  assign in_ready_o   = !prod_valid_q || ctrl.advance;
  assign ctrl.load    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      prod_valid_q <= in_valid_i;
    end
  end

  // One lane per panel.
  dpmppt_lane #(
    .SampleWidth(SampleWidth)
  ) u_lane_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .volts_i     (x_panel_volts_i),
    .amps_i      (x_panel_amps_i),
    .duty_step_i (duty_step_val_q),
    .result_o    (x_result)
  );

  dpmppt_lane #(
    .SampleWidth(SampleWidth)
  ) u_lane_y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .volts_i     (y_panel_volts_i),
    .amps_i      (y_panel_amps_i),
    .duty_step_i (duty_step_val_q),
    .result_o    (y_result)
  );

  // Output register joins both lanes.
  dpmppt_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (ctrl.advance),
    .x_result_i   (x_result),
    .y_result_i   (y_result),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .can_load_o   (can_load),
    .x_duty_out_o (x_duty_out_o),
    .y_duty_out_o (y_duty_out_o),
    .x_dir_out_o  (x_dir_out_o),
    .y_dir_out_o  (y_dir_out_o)
  );

endmodule

/* design/dpmppt_lane.sv */
// ----------------------------------------------------------------------------
// Dual-panel MPPT tracking lane
// Registers one panel's power product, then compares it with the stored
// power, toggles the direction on a drop and steps the duty cycle.
// ----------------------------------------------------------------------------
module dpmppt_lane #(
  parameter int unsigned SampleWidth = dpmppt_pkg::SampleWidthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dpmppt_pkg::lane_ctrl_t              ctrl_i,
  input  logic [dpmppt_pkg::FieldWidth-1:0]   volts_i,
  input  logic [dpmppt_pkg::FieldWidth-1:0]   amps_i,
  input  logic [dpmppt_pkg::DutyWidth-1:0]    duty_step_i,
  output dpmppt_pkg::lane_result_t            result_o
);
  import dpmppt_pkg::*;

  localparam int unsigned ProdWidth = 2 * SampleWidth;

  logic [ProdWidth-1:0]  prod_d, prod_q;
  logic [PowerWidth-1:0] power;
  logic [PowerWidth-1:0] prev_power_q;
  logic                  dir_q, dir_d;
  logic [DutyWidth-1:0]  duty_q, duty_d;

  // Product stage: only the low sample bits take part.
  assign prod_d = ProdWidth'(volts_i[SampleWidth-1:0]) * ProdWidth'(amps_i[SampleWidth-1:0]);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prod_q <= prod_d;
    end
  end

  // Observe and perturb: a drop in power reverses the direction.
  assign power  = PowerWidth'(prod_q);
  assign dir_d  = (power < prev_power_q) ? ~dir_q : dir_q;
  assign duty_d = dir_d ? (duty_q + duty_step_i) : (duty_q - duty_step_i);

  // Tracking state, updated once per word in order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_power_q <= PowerReset;
      dir_q        <= 1'b0;
      duty_q       <= DutyReset;
    end else if (ctrl_i.advance) begin
      prev_power_q <= power;
      dir_q        <= dir_d;
      duty_q       <= duty_d;
    end
  end

  assign result_o.duty = duty_d;
  assign result_o.dir  = dir_d;

endmodule

/* design/dpmppt_merge.sv */
// ----------------------------------------------------------------------------
// Dual-panel MPPT result merge
// Joins the results of both lanes into one output word and holds it in the
// output register until the receiver takes it.
// ----------------------------------------------------------------------------
module dpmppt_merge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  dpmppt_pkg::lane_result_t           x_result_i,
  input  dpmppt_pkg::lane_result_t           y_result_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic                               can_load_o,
  output logic [dpmppt_pkg::DutyWidth-1:0]   x_duty_out_o,
  output logic [dpmppt_pkg::DutyWidth-1:0]   y_duty_out_o,
  output logic                               x_dir_out_o,
  output logic                               y_dir_out_o
);
  import dpmppt_pkg::*;

  logic         valid_q, valid_d;
  lane_result_t x_q, y_q;

  // The register takes a new word when it is empty or being drained.
  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q <= x_result_i;
      y_q <= y_result_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign x_duty_out_o = x_q.duty;
  assign y_duty_out_o = y_q.duty;
  assign x_dir_out_o  = x_q.dir;
  assign y_dir_out_o  = y_q.dir;

endmodule

/* sim/tb_dual_panel_mppt_perturb_observe_core.sv */
// ----------------------------------------------------------------------------
// Testbench for the dual-panel perturb-and-observe MPPT core
// A directed table is walked first: reset state, sample extremes, equal power
// and zero power. Random phases follow, each with its own duty step (zero,
// one, 255 and others among them). Every accepted input word is run through
// a local tracker model, and each output word is compared field by field
// with the oldest expected word. Sender gaps and receiver stalls are random,
// and one phase holds the receiver off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_dual_panel_mppt_perturb_observe_core;

  import dpmppt_pkg::*;

  localparam int unsigned SampleW = FieldWidth;
  localparam int unsigned NumRows = 18;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned PhaseWords = 205;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned DrainCycles = 8;
  localparam longint unsigned TimeoutTime = 64'd4_000_000;

  // One output word as the core returns it.
  typedef struct packed {
    logic [DutyWidth-1:0] x_duty;
    logic [DutyWidth-1:0] y_duty;
    logic                 x_dir;
    logic                 y_dir;
  } duty_word_t;

  // One row of the directed table; has_want marks a result typed in by hand.
  typedef struct packed {
    logic [SampleW-1:0] xv;
    logic [SampleW-1:0] xa;
    logic [SampleW-1:0] yv;
    logic [SampleW-1:0] ya;
    logic               has_want;
    duty_word_t         want;
  } sample_row_t;

  localparam duty_word_t NoWant = '0;

  // Starts from reset with a step of 6: the first word always raises both
  // directions, equal power keeps them, and a drop to zero power turns back.
  localparam sample_row_t DirectedRows [NumRows] = '{
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{8'd69, 8'd69, 1'b1, 1'b1}},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{8'd75, 8'd75, 1'b1, 1'b1}},
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, '{8'd69, 8'd69, 1'b0, 1'b0}},
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, '{8'd63, 8'd63, 1'b0, 1'b0}},
    '{16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF, 1'b0, NoWant},
    '{16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001, 1'b0, NoWant},
    '{16'h8000, 16'h8000, 16'h8000, 16'h0002, 1'b0, NoWant},
    '{16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1'b0, NoWant},
    '{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b0, NoWant},
    '{16'h0001, 16'h0001, 16'h0002, 16'h0001, 1'b0, NoWant},
    '{16'h00FF, 16'hFF00, 16'hFF00, 16'h00FF, 1'b0, NoWant},
    '{16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 1'b0, NoWant},
    '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, NoWant},
    '{16'h1234, 16'h5678, 16'h8765, 16'h4321, 1'b0, NoWant},
    '{16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFE, 1'b0, NoWant},
    '{16'h0100, 16'h0100, 16'h0010, 16'h0010, 1'b0, NoWant},
    '{16'h0200, 16'h0100, 16'h0020, 16'h0010, 1'b0, NoWant},
    '{16'h0400, 16'h0100, 16'h0040, 16'h0010, 1'b0, NoWant}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [DutyWidth-1:0] cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [SampleW-1:0]   x_panel_volts_i;
  logic [SampleW-1:0]   x_panel_amps_i;
  logic [SampleW-1:0]   y_panel_volts_i;
  logic [SampleW-1:0]   y_panel_amps_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [DutyWidth-1:0] x_duty_out_o;
  logic [DutyWidth-1:0] y_duty_out_o;
  logic                 x_dir_out_o;
  logic                 y_dir_out_o;

  // Tracker state kept by the testbench.
  logic [DutyWidth-1:0]  duty_step_now;
  logic [PowerWidth-1:0] x_last_power;
  logic [PowerWidth-1:0] y_last_power;
  logic                  x_dir_now;
  logic                  y_dir_now;
  logic [DutyWidth-1:0]  x_duty_now;
  logic [DutyWidth-1:0]  y_duty_now;

  duty_word_t duty_expect_q [$];
  int unsigned mismatch_count;
  int unsigned burst_left;
  bit long_hold_req;

  dual_panel_mppt_perturb_observe_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .x_panel_volts_i (x_panel_volts_i),
    .x_panel_amps_i  (x_panel_amps_i),
    .y_panel_volts_i (y_panel_volts_i),
    .y_panel_amps_i  (y_panel_amps_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .x_duty_out_o    (x_duty_out_o),
    .y_duty_out_o    (y_duty_out_o),
    .x_dir_out_o     (x_dir_out_o),
    .y_dir_out_o     (y_dir_out_o)
  );

  // Clock with a period of 20.
  always #10 clk_i = ~clk_i;

  // Steps both panels by one sample word and returns the new duties.
  function automatic duty_word_t predict_duty(input logic [SampleW-1:0] xv,
                                              input logic [SampleW-1:0] xa,
                                              input logic [SampleW-1:0] yv,
                                              input logic [SampleW-1:0] ya);
    logic [PowerWidth-1:0] x_power;
    logic [PowerWidth-1:0] y_power;
    duty_word_t            next_word;
    x_power = xv * xa;
    y_power = yv * ya;
    // A drop in power turns the perturbation around.
    if (x_power < x_last_power) begin
      x_dir_now = ~x_dir_now;
    end
    if (y_power < y_last_power) begin
      y_dir_now = ~y_dir_now;
    end
    x_last_power = x_power;
    y_last_power = y_power;
    // Duties wrap at eight bits in both directions.
    x_duty_now = x_dir_now ? x_duty_now + duty_step_now : x_duty_now - duty_step_now;
    y_duty_now = y_dir_now ? y_duty_now + duty_step_now : y_duty_now - duty_step_now;
    next_word = '{x_duty_now, y_duty_now, x_dir_now, y_dir_now};
    return next_word;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned actual);
    if (want != actual) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, actual);
      mismatch_count++;
    end
  endtask

  // Offers one input word and records its expected result once accepted.
  task automatic send_word(input logic [SampleW-1:0] xv, input logic [SampleW-1:0] xa,
                           input logic [SampleW-1:0] yv, input logic [SampleW-1:0] ya,
                           input logic has_want, input duty_word_t want);
    duty_word_t predicted;
    in_valid_i      <= 1'b1;
    x_panel_volts_i <= xv;
    x_panel_amps_i  <= xa;
    y_panel_volts_i <= yv;
    y_panel_amps_i  <= ya;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = predict_duty(xv, xa, yv, ya);
    duty_expect_q.push_back(has_want ? want : predicted);
  endtask

  // Inserts a random gap between bursts unless the sender must stay busy.
  task automatic pace_sender(input bit steady);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) begin
        gap = 0;
      end
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // Drops valid and waits until every expected word has come back.
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (duty_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_step(input logic [DutyWidth-1:0] step);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= step;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i   <= 1'b0;
    duty_step_now = step;
  endtask

  // Moves a sample mostly in small steps, as a real panel would, with
  // occasional jumps, extremes and repeats.
  task automatic next_sample(inout logic [SampleW-1:0] sample);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      sample = sample + SampleW'($urandom_range(0, 64)) - SampleW'(32);
    end else if (pick <= 7) begin
      sample = SampleW'($urandom);
    end else if (pick == 8) begin
      case ($urandom_range(0, 5))
        0: sample = 16'h0000;
        1: sample = 16'h0001;
        2: sample = 16'h7FFF;
        3: sample = 16'h8000;
        4: sample = 16'hFFFE;
        default: sample = 16'hFFFF;
      endcase
    end
  endtask

  // Output side: compare each accepted word with the oldest expectation.
  always @(posedge clk_i) begin
    duty_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (duty_expect_q.size() == 0) begin
        $display("%0t: output word with nothing expected, actual %0d %0d %0d %0d",
                 $time, x_duty_out_o, y_duty_out_o, x_dir_out_o, y_dir_out_o);
        mismatch_count++;
      end else begin
        want = duty_expect_q.pop_front();
        check_field("x_duty_out", want.x_duty, x_duty_out_o);
        check_field("y_duty_out", want.y_duty, y_duty_out_o);
        check_field("x_dir_out", want.x_dir, x_dir_out_o);
        check_field("y_dir_out", want.y_dir, y_dir_out_o);
      end
    end
  end

  // Receiver: stretches of steady, random or patterned stalls, plus one
  // long hold-off on request.
  initial begin : receiver
    int unsigned stretch;
    int unsigned mode;
    logic [7:0]  ready_mask;
    out_ready_i = 1'b0;
    forever begin
      if (long_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        stretch    = $urandom_range(4, 40);
        mode       = $urandom_range(0, 3);
        ready_mask = 8'($urandom);
        for (int unsigned i = 0; i < stretch; i++) begin
          case (mode)
            0: out_ready_i <= 1'b1;
            1: out_ready_i <= 1'($urandom_range(0, 1));
            2: out_ready_i <= ready_mask[i % 8];
            default: out_ready_i <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Stimulus: directed table, then random phases with new duty steps.
  initial begin : stimulus
    logic [DutyWidth-1:0] phase_steps [NumPhases];
    logic [SampleW-1:0]   xv;
    logic [SampleW-1:0]   xa;
    logic [SampleW-1:0]   yv;
    logic [SampleW-1:0]   ya;
    logic [SampleW-1:0]   swap;
    bit                   steady;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    x_panel_volts_i = '0;
    x_panel_amps_i  = '0;
    y_panel_volts_i = '0;
    y_panel_amps_i  = '0;
    mismatch_count  = 0;
    burst_left      = 0;
    long_hold_req   = 1'b0;
    duty_step_now   = DutyStepReset;
    x_last_power    = PowerReset;
    y_last_power    = PowerReset;
    x_dir_now       = 1'b0;
    y_dir_now       = 1'b0;
    x_duty_now      = DutyReset;
    y_duty_now      = DutyReset;
    phase_steps = '{8'd1, 8'd255, 8'd0, 8'd128, 8'($urandom_range(1, 255)), 8'd6,
                    8'd2, 8'($urandom_range(1, 255))};
    xv = 16'h4000;
    xa = 16'h0800;
    yv = 16'h3000;
    ya = 16'h0C00;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[r]) begin
      pace_sender(1'b0);
      send_word(DirectedRows[r].xv, DirectedRows[r].xa, DirectedRows[r].yv,
                DirectedRows[r].ya, DirectedRows[r].has_want, DirectedRows[r].want);
    end

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      settle_idle();
      write_step(phase_steps[ph]);
      // The second phase keeps the sender busy while the receiver holds off.
      steady = (ph == 1);
      if (steady) begin
        long_hold_req = 1'b1;
      end
      for (int unsigned n = 0; n < PhaseWords; n++) begin
        case ($urandom_range(0, 9))
          0: ;  // repeat the last samples: equal power on both panels
          1: begin
            swap = xv;
            xv   = xa;
            xa   = swap;
          end
          default: begin
            next_sample(xv);
            next_sample(xa);
            next_sample(yv);
            next_sample(ya);
          end
        endcase
        pace_sender(steady);
        send_word(xv, xa, yv, ya, 1'b0, NoWant);
      end
    end

    settle_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && duty_expect_q.size() == 0) begin
      $display("tb_dual_panel_mppt_perturb_observe_core: PASS");
    end else begin
      $display("tb_dual_panel_mppt_perturb_observe_core: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(TimeoutTime);
    $display("%0t: timeout with %0d words still expected", $time, duty_expect_q.size());
    $display("tb_dual_panel_mppt_perturb_observe_core: FAIL");
    $finish;
  end

endmodule

/* files.f */
design/dpmppt_pkg.sv
design/dpmppt_lane.sv
design/dpmppt_merge.sv
design/dual_panel_mppt_perturb_observe_core.sv
sim/tb_dual_panel_mppt_perturb_observe_core.sv
